// File: sv/b32e_pkg.sv
// shared types, constants and the symbol alphabet function for the base32 encoder
`timescale 1ns / 1ps

package b32e_pkg;

   localparam int unsigned SymbolWidth = 5;
   localparam int unsigned CharWidth   = 7;
   localparam int unsigned MaxSymbols  = 3;
   localparam int unsigned CountWidth  = 2;
   localparam int unsigned ResWidth    = 4;
   localparam int unsigned ResCntWidth = 3;

   localparam logic [SymbolWidth-1:0] LetterCount = 5'd26;
   localparam logic [CharWidth-1:0]   LetterBase  = 7'd97;
   // ascii '2' less the number of letters
   localparam logic [CharWidth-1:0]   DigitBase   = 7'd24;

   typedef logic [SymbolWidth-1:0] symbol_type;
   typedef logic [CharWidth-1:0]   char_type;
   typedef logic [CountWidth-1:0]  count_type;
   typedef logic [ResWidth-1:0]    res_bits_type;
   typedef logic [ResCntWidth-1:0] res_cnt_type;

   typedef struct packed {
      char_type [MaxSymbols-1:0] chars;
      count_type                 count;
   } enc_word_type;

   function automatic char_type sym_char(input symbol_type idx);
      char_type wide;
      wide = {2'b00, idx};
      if (idx < LetterCount) begin
         return wide + LetterBase;
      end else begin
         return wide + DigitBase;
      end
   endfunction

endpackage

// File: sv/b32e_if.sv
// handshake channel interfaces for byte input and character output
`timescale 1ns / 1ps

interface b32e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32e_rsp_if;
   logic                valid;
   logic                ready;
   b32e_pkg::char_type  symbol_char;
   logic                final_symbol;

   modport source (output valid, output symbol_char, output final_symbol, input ready);
   modport sink   (input valid, input symbol_char, input final_symbol, output ready);
endinterface

// File: sv/b32e_encode.sv
// splits leftover bits plus one byte into base32 characters and the next leftover
`timescale 1ns / 1ps

module b32e_encode (
   input  b32e_pkg::res_bits_type res_bits,
   input  b32e_pkg::res_cnt_type  res_cnt,
   input  logic [7:0]             data_byte,
   input  logic                   final_byte,
   output b32e_pkg::enc_word_type enc_word,
   output b32e_pkg::res_bits_type next_bits,
   output b32e_pkg::res_cnt_type  next_cnt
);

   logic [11:0]            acc;
   logic                   two_syms;
   logic [2:0]             sh0;
   logic [1:0]             sh1;
   logic [11:0]            shifted0;
   logic [11:0]            shifted1;
   logic [2:0]             left_cnt;
   logic [11:0]            left_mask;
   logic [11:0]            left_all;
   b32e_pkg::res_bits_type left_bits;
   logic [5:0]             flush_wide;
   logic                   flush;
   b32e_pkg::symbol_type   sym0;
   b32e_pkg::symbol_type   sym1;
   b32e_pkg::symbol_type   sym_flush;

   always_comb begin
      acc        = {res_bits, data_byte};
      two_syms   = (res_cnt >= 3'd2);
      sh0        = res_cnt + 3'd3;
      sh1        = 2'(res_cnt - 3'd2);
      shifted0   = acc >> sh0;
      shifted1   = acc >> sh1;
      sym0       = shifted0[4:0];
      sym1       = shifted1[4:0];
      left_cnt   = two_syms ? (res_cnt - 3'd2) : (res_cnt + 3'd3);
      left_mask  = (12'd1 << left_cnt) - 12'd1;
      left_all   = acc & left_mask;
      left_bits  = left_all[3:0];
      // pad leftover with zeros on the right
      flush_wide = {2'b00, left_bits} << (3'd5 - left_cnt);
      sym_flush  = flush_wide[4:0];
      flush      = final_byte && (left_cnt != 3'd0);

      enc_word.chars[0] = b32e_pkg::sym_char(sym0);
      enc_word.chars[1] = two_syms ? b32e_pkg::sym_char(sym1)
                                   : b32e_pkg::sym_char(sym_flush);
      enc_word.chars[2] = b32e_pkg::sym_char(sym_flush);
      enc_word.count    = {1'b0, two_syms} + 2'd1 + {1'b0, flush};

      next_bits = final_byte ? '0 : left_bits;
      next_cnt  = final_byte ? '0 : left_cnt;
   end

endmodule

// File: sv/b32e_symbol_buffer.sv
// result register holding up to three characters, sent one per cycle while rsp_word.ready is high
`timescale 1ns / 1ps

module b32e_symbol_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  b32e_pkg::enc_word_type load_word,
   output logic                   can_load,
   b32e_rsp_if.source             rsp_word
);

   b32e_pkg::char_type [b32e_pkg::MaxSymbols-1:0] chars_ff;
   b32e_pkg::char_type [b32e_pkg::MaxSymbols-1:0] chars_in;
   b32e_pkg::count_type                           count_ff;
   b32e_pkg::count_type                           count_in;
   logic                                          take;

   assign take     = rsp_word.valid && rsp_word.ready;
   assign can_load = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_word.ready);

   assign rsp_word.valid        = (count_ff != 2'd0);
   assign rsp_word.symbol_char  = chars_ff[0];
   assign rsp_word.final_symbol = (count_ff == 2'd1);

   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      if (load) begin
         chars_in = load_word.chars;
         count_in = load_word.count;
      end else if (take) begin
         chars_in[0] = chars_ff[1];
         chars_in[1] = chars_ff[2];
         count_in    = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

endmodule

// File: sv/base32_byte_encoder_core.sv
// top level of the lowercase unpadded base32 byte encoder
//
// req_word carries one byte per word with final_byte marking the last
// byte of a message; rsp_word carries one ascii character per word
// (a-z, 2-7) with final_symbol set on the last character a byte causes.
// each byte gives one or two characters, and a final byte that leaves
// leftover bits gives one more, zero padded on the right; no '=' is sent.
// the first character of a byte is offered the cycle after the
// byte is taken. the single character output sends one word per cycle
// while rsp_word.ready is high; a new byte can be taken in the same
// cycle the last character of the previous one leaves, so the output
// does not idle between bytes while the next byte is waiting.
// reset clears the leftover bits and count and empties the result
// register. while rsp_word.ready is low the current character holds and
// req_word.ready drops once the result register has nothing it can free.
`timescale 1ns / 1ps

module base32_byte_encoder_core (
   input  logic       clock,
   input  logic       reset,
   b32e_req_if.sink   req_word,
   b32e_rsp_if.source rsp_word
);

   b32e_pkg::res_bits_type res_bits_ff;
   b32e_pkg::res_bits_type res_bits_in;
   b32e_pkg::res_cnt_type  res_cnt_ff;
   b32e_pkg::res_cnt_type  res_cnt_in;
   b32e_pkg::enc_word_type enc_word;
   logic                   can_load;
   logic                   accept;

   assign req_word.ready = can_load;
   assign accept         = req_word.valid && can_load;

   b32e_encode u_encode (
      .res_bits   (res_bits_ff),
      .res_cnt    (res_cnt_ff),
      .data_byte  (req_word.data_byte),
      .final_byte (req_word.final_byte),
      .enc_word   (enc_word),
      .next_bits  (res_bits_in),
      .next_cnt   (res_cnt_in)
   );

   b32e_symbol_buffer u_symbol_buffer (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_word (enc_word),
      .can_load  (can_load),
      .rsp_word  (rsp_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         res_bits_ff <= '0;
         res_cnt_ff  <= '0;
      end else if (accept) begin
         res_bits_ff <= res_bits_in;
         res_cnt_ff  <= res_cnt_in;
      end
   end

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the lowercase unpadded base32 byte encoder
`timescale 1ns / 1ps

module tb_top;

   localparam logic [8*32-1:0] B32_ALPHABET = "abcdefghijklmnopqrstuvwxyz234567";

   typedef struct {
      b32e_pkg::char_type symbol_char;
      logic               final_symbol;
   } char_word_type;

   logic clock;
   logic reset;

   b32e_req_if req_w ();
   b32e_rsp_if rsp_w ();

   base32_byte_encoder_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_w),
      .rsp_word (rsp_w)
   );

   char_word_type          char_queue[$];
   b32e_pkg::res_bits_type carry_bits;
   b32e_pkg::res_cnt_type  carry_count;
   int                     error_count;
   int                     sink_hold;
   bit                     idle_on;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic b32e_pkg::char_type alphabet_char(input b32e_pkg::symbol_type idx);
      logic [7:0] ascii;
      ascii = B32_ALPHABET[8*(31-idx) +: 8];
      return ascii[6:0];
   endfunction

   // join the byte below the carried bits, emit every full group msb first, and on the last byte a zero padded leftover
   function automatic void predict_chars(input logic [7:0] data_byte, input logic last_byte);
      logic [11:0]          acc;
      int unsigned          bits;
      b32e_pkg::symbol_type syms[3];
      int                   n;
      char_word_type        w;
      acc  = {carry_bits, data_byte};
      bits = carry_count + 8;
      n    = 0;
      while (bits >= 5) begin
         syms[n] = b32e_pkg::symbol_type'((acc >> (bits - 5)) & 12'h01f);
         n++;
         bits -= 5;
      end
      acc &= (12'h001 << bits) - 12'h001;
      if (last_byte) begin
         if (bits > 0) begin
            syms[n] = b32e_pkg::symbol_type'((acc << (5 - bits)) & 12'h01f);
            n++;
         end
         carry_bits  = '0;
         carry_count = '0;
      end else begin
         carry_bits  = acc[3:0];
         carry_count = b32e_pkg::res_cnt_type'(bits);
      end
      for (int i = 0; i < n; i++) begin
         w.symbol_char  = alphabet_char(syms[i]);
         w.final_symbol = (i == n - 1);
         char_queue.push_back(w);
      end
   endfunction

   task automatic report_mismatch(input string what, input int exp_v, input int got_v);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
      error_count++;
   endtask

   task automatic send_byte(input logic [7:0] data_byte, input logic last_byte);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_w.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_w.valid      <= 1'b1;
      req_w.data_byte  <= data_byte;
      req_w.final_byte <= last_byte;
      @(posedge clock);
      while (!req_w.ready) @(posedge clock);
      predict_chars(data_byte, last_byte);
   endtask

   task automatic wait_drain();
      req_w.valid <= 1'b0;
      @(posedge clock);
      while (char_queue.size() != 0) @(posedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   task automatic test_single_bytes();
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h01, 1'b1);
   endtask

   // forty bits close on a group boundary, so the flush adds nothing
   task automatic test_no_leftover();
      for (int i = 0; i < 5; i++) send_byte(8'hff, i == 4);
      for (int i = 0; i < 5; i++) send_byte(8'h00, i == 4);
   endtask

   // fourth byte starts with four carried bits, two chars plus a flush
   task automatic test_three_chars();
      send_byte(8'ha5, 1'b0);
      send_byte(8'h5a, 1'b0);
      send_byte(8'hc3, 1'b0);
      send_byte(8'h3c, 1'b1);
   endtask

   task automatic test_backpressure();
      sink_hold = 80;
      send_message(20);
   endtask

   // sender stops mid-message until the output has emptied
   task automatic test_drain_pause();
      for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      wait_drain();
      send_message(6);
   endtask

   task automatic test_random_messages(input int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
         send_message(len);
         sent += len;
      end
   endtask

   task automatic test_full_rate(input int items);
      idle_on = 1'b0;
      test_random_messages(items);
   endtask

   initial begin
      int hold;
      forever begin
         if (sink_hold > 0) begin
            hold = sink_hold;
            sink_hold = 0;
            rsp_w.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_w.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_w.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_words
      char_word_type exp_w;
      if (!reset && rsp_w.valid && rsp_w.ready) begin
         if (char_queue.size() == 0) begin
            report_mismatch("unexpected word, char", 0, int'(rsp_w.symbol_char));
         end else begin
            exp_w = char_queue.pop_front();
            if (rsp_w.symbol_char !== exp_w.symbol_char) begin
               report_mismatch("symbol_char", int'(exp_w.symbol_char),
                               int'(rsp_w.symbol_char));
            end
            if (rsp_w.final_symbol !== exp_w.final_symbol) begin
               report_mismatch("final_symbol", int'(exp_w.final_symbol),
                               int'(rsp_w.final_symbol));
            end
         end
      end
   end

   initial begin
      error_count      = 0;
      sink_hold        = 0;
      idle_on          = 1'b1;
      carry_bits       = '0;
      carry_count      = '0;
      reset            <= 1'b1;
      req_w.valid      <= 1'b0;
      req_w.data_byte  <= 8'h00;
      req_w.final_byte <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_bytes();
      test_no_leftover();
      test_three_chars();
      test_backpressure();
      test_drain_pause();
      test_random_messages(250);
      test_full_rate(60);

      wait_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0 && char_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/b32e_pkg.sv
sv/b32e_if.sv
sv/b32e_encode.sv
sv/b32e_symbol_buffer.sv
sv/base32_byte_encoder_core.sv
tb/tb_top.sv
